// ----- src/isc_pkg.sv -----
package isc_pkg;

	localparam int unsigned PATCH_W   = 18;
	localparam int unsigned PIXEL_W   = 24;
	localparam int unsigned BATCH_W   = 6;
	localparam int unsigned SRC_X_W   = 14;
	localparam int unsigned SRC_Y_W   = 26;
	localparam int unsigned SRC_CH_W  = 19;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 13;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH   = 3'd0,
		REG_IMAGE_HEIGHT  = 3'd1,
		REG_CHANNEL_COUNT = 3'd2,
		REG_KERNEL_WIDTH  = 3'd3,
		REG_KERNEL_HEIGHT = 3'd4,
		REG_BEGIN_X       = 3'd5,
		REG_BEGIN_Y       = 3'd6,
		REG_BEGIN_CHANNEL = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [SRC_X_W-1:0]  source_x;
		logic [SRC_Y_W-1:0]  source_y;
		logic [SRC_CH_W-1:0] source_channel;
		logic [BATCH_W-1:0]  source_batch;
		logic                inside_res;
	} res_t;

endpackage

// ----- src/isc_if.sv -----
interface isc_in_if;
	import isc_pkg::*;
	logic               valid;
	logic               ready;
	logic [PATCH_W-1:0] patch_index;
	logic [PIXEL_W-1:0] pixel_index;
	logic [BATCH_W-1:0] batch_index;
	modport source (output valid, patch_index, pixel_index, batch_index, input ready);
	modport sink (input valid, patch_index, pixel_index, batch_index, output ready);
endinterface

interface isc_out_if;
	import isc_pkg::*;
	logic                valid;
	logic                ready;
	logic [SRC_X_W-1:0]  source_x;
	logic [SRC_Y_W-1:0]  source_y;
	logic [SRC_CH_W-1:0] source_channel;
	logic [BATCH_W-1:0]  source_batch;
	logic                inside_res;
	modport source (output valid, source_x, source_y, source_channel, source_batch,
		inside_res, input ready);
	modport sink (input valid, source_x, source_y, source_channel, source_batch,
		inside_res, output ready);
endinterface

interface isc_cfg_if;
	import isc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- src/isc_div_pipe.sv -----
module isc_div_pipe #(
	parameter int unsigned NUM_W = 24,
	parameter int unsigned DEN_W = 13
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo,
	output logic [DEN_W-1:0] rem
);

	// Restoring division, one quotient bit per stage, most significant first.
	// The shift register nq_s holds the unused dividend bits and the quotient bits found so far.
	logic [DEN_W-1:0] rem_s [NUM_W];
	logic [NUM_W-1:0] nq_s  [NUM_W];

	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		logic [DEN_W-1:0] rem_in;
		logic [NUM_W-1:0] nq_in;
		logic [DEN_W:0]   trial;
		logic             ge;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign nq_in  = num;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign nq_in  = nq_s[k-1];
		end

		assign trial = {rem_in, nq_in[NUM_W-1]};
		assign ge    = trial >= {1'b0, den};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
				nq_s[k]  <= {nq_in[NUM_W-2:0], ge};
			end
		end
	end

	assign quo = nq_s[NUM_W-1];
	assign rem = rem_s[NUM_W-1];

endmodule

// ----- src/im2col_source_coordinate.sv -----
// im2col source coordinate generator.
// Each item on in_ch names one element of the im2col matrix by patch index,
// pixel index and batch index. The matching result on out_ch gives the input
// tensor coordinate (x, y, channel, batch) and inside_res, which is low when
// the coordinate falls outside the tensor and the element reads as zero.
// The cfg channel writes the eight geometry registers by index; it is always
// ready and must only be used while no item is in flight.
// From the input transfer to the result on out_ch an item passes 24 divider
// stages (one quotient bit per stage over the 24-bit pixel index), two
// arithmetic stages and the output register. One item is accepted every
// cycle. When out_ch stalls, the pipeline keeps running until a skid register
// behind the output fills, then the whole pipeline holds and in_ch.ready stays
// low until out_ch takes the waiting result; nothing is lost or repeated.
// Reset clears all valid bits and loads the registers with a one by one image
// and kernel, one channel and zero begin offsets.
module im2col_source_coordinate #(
	parameter int unsigned BATCH_COUNT = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	isc_in_if.sink         in_ch,
	isc_out_if.source      out_ch,
	isc_cfg_if.sink        cfg
);
	import isc_pkg::*;

	localparam int unsigned DIV_LAT = PIXEL_W;

	logic [12:0]       image_width_q;
	logic [12:0]       image_height_q;
	logic [10:0]       channel_count_q;
	logic [4:0]        kernel_width_q;
	logic [4:0]        kernel_height_q;
	logic signed [4:0] begin_x_q;
	logic signed [4:0] begin_y_q;
	logic [9:0]        begin_channel_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q   <= 13'd1;
			image_height_q  <= 13'd1;
			channel_count_q <= 11'd1;
			kernel_width_q  <= 5'd1;
			kernel_height_q <= 5'd1;
			begin_x_q       <= '0;
			begin_y_q       <= '0;
			begin_channel_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_IMAGE_WIDTH:   image_width_q   <= cfg.data;
				REG_IMAGE_HEIGHT:  image_height_q  <= cfg.data;
				REG_CHANNEL_COUNT: channel_count_q <= cfg.data[10:0];
				REG_KERNEL_WIDTH:  kernel_width_q  <= cfg.data[4:0];
				REG_KERNEL_HEIGHT: kernel_height_q <= cfg.data[4:0];
				REG_BEGIN_X:       begin_x_q       <= cfg.data[4:0];
				REG_BEGIN_Y:       begin_y_q       <= cfg.data[4:0];
				REG_BEGIN_CHANNEL: begin_channel_q <= cfg.data[9:0];
				default: ;
			endcase
		end
	end

	// A zero divisor is treated as one.
	logic [12:0] width_eff;
	logic [4:0]  kw_eff;
	logic [4:0]  kh_eff;
	logic [9:0]  area_eff;

	assign width_eff = (image_width_q == '0) ? 13'd1 : image_width_q;
	assign kw_eff    = (kernel_width_q == '0) ? 5'd1 : kernel_width_q;
	assign kh_eff    = (kernel_height_q == '0) ? 5'd1 : kernel_height_q;
	assign area_eff  = 10'(kw_eff) * 10'(kh_eff);

	logic en;
	logic skid_valid_q;

	assign en          = !skid_valid_q;
	assign in_ch.ready = en;

	logic in_xfer;
	assign in_xfer = in_ch.valid && in_ch.ready;

	logic               div_valid_s [DIV_LAT];
	logic [BATCH_W-1:0] div_batch_s [DIV_LAT];

	for (genvar k = 0; k < DIV_LAT; k++) begin : g_delay
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_valid_s[k] <= 1'b0;
			end else if (en) begin
				div_valid_s[k] <= (k == 0) ? in_xfer : div_valid_s[(k == 0) ? 0 : k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				div_batch_s[k] <= (k == 0) ? in_ch.batch_index : div_batch_s[(k == 0) ? 0 : k-1];
			end
		end
	end

	logic [PIXEL_W-1:0] quo_w;
	logic [12:0]        rem_w;
	logic [PIXEL_W-1:0] quo_kw;
	logic [4:0]         rem_kw;
	logic [PIXEL_W-1:0] quo_a;
	logic [9:0]         rem_a;

	isc_div_pipe #(.NUM_W(PIXEL_W), .DEN_W(13)) u_div_pixel (
		.clk (clk),
		.en  (en),
		.num (in_ch.pixel_index),
		.den (width_eff),
		.quo (quo_w),
		.rem (rem_w)
	);

	isc_div_pipe #(.NUM_W(PIXEL_W), .DEN_W(5)) u_div_kw (
		.clk (clk),
		.en  (en),
		.num (PIXEL_W'(in_ch.patch_index)),
		.den (kw_eff),
		.quo (quo_kw),
		.rem (rem_kw)
	);

	isc_div_pipe #(.NUM_W(PIXEL_W), .DEN_W(10)) u_div_area (
		.clk (clk),
		.en  (en),
		.num (PIXEL_W'(in_ch.patch_index)),
		.den (area_eff),
		.quo (quo_a),
		.rem (rem_a)
	);

	// The row inside the patch is (patch / kw) - (patch / area) * kh.
	logic                valid_s1;
	logic signed [14:0]  sx_s1;
	logic [PIXEL_W-1:0]  y_s1;
	logic [PATCH_W-1:0]  qkw_s1;
	logic [22:0]         prod_s1;
	logic [SRC_CH_W-1:0] kc_s1;
	logic [BATCH_W-1:0]  batch_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= div_valid_s[DIV_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s1    <= signed'(15'(rem_w)) + signed'(15'(rem_kw)) + 15'(begin_x_q);
			y_s1     <= quo_w;
			qkw_s1   <= quo_kw[PATCH_W-1:0];
			prod_s1  <= quo_a[PATCH_W-1:0] * kh_eff;
			kc_s1    <= SRC_CH_W'(quo_a[PATCH_W-1:0]) + SRC_CH_W'(begin_channel_q);
			batch_s1 <= div_batch_s[DIV_LAT-1];
		end
	end

	logic [4:0]         ky;
	logic signed [26:0] sy;
	logic               sx_in;
	logic               sy_in;
	logic               kc_in;
	logic               nb_in;

	assign ky    = 5'(qkw_s1 - prod_s1[PATCH_W-1:0]);
	assign sy    = signed'(27'(y_s1)) + signed'(27'(ky)) + 27'(begin_y_q);
	assign sx_in = !sx_s1[14] && (sx_s1[13:0] < 14'(image_width_q));
	assign sy_in = !sy[26] && (sy[25:0] < 26'(image_height_q));
	assign kc_in = kc_s1 < SRC_CH_W'(channel_count_q);
	assign nb_in = 32'(batch_s1) < BATCH_COUNT;

	logic valid_s2;
	res_t res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s2.source_x       <= sx_s1[13:0];
			res_s2.source_y       <= sy[25:0];
			res_s2.source_channel <= kc_s1;
			res_s2.source_batch   <= batch_s1;
			res_s2.inside_res     <= sx_in && sy_in && kc_in && nb_in;
		end
	end

	// Output register with a skid register behind it.
	logic push;
	logic out_valid_q;
	res_t out_q;
	res_t skid_q;

	assign push = en && valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ch.ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ch.ready || !out_valid_q) begin
			out_q <= skid_valid_q ? skid_q : res_s2;
		end else if (push) begin
			skid_q <= res_s2;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.source_x       = out_q.source_x;
	assign out_ch.source_y       = out_q.source_y;
	assign out_ch.source_channel = out_q.source_channel;
	assign out_ch.source_batch   = out_q.source_batch;
	assign out_ch.inside_res     = out_q.inside_res;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds a result while the output register is empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !out_ch.ready))
		else $error("skid register filled without a stalled output");

	a_inside_coords: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.inside_res) |->
			(!out_q.source_x[SRC_X_W-1] && !out_q.source_y[SRC_Y_W-1]))
		else $error("inside flag set on a negative coordinate");

	a_stage_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> out_valid_q)
		else $error("result leaving the pipeline was dropped");

endmodule
